>>> hw/rtl/tap_pkg.sv
// Shared types and constants for the tensor axis permute address generator.
// No dependencies; imported by every other file of the block.
package tap_pkg;

  localparam int MAX_RANK      = 4;
  localparam int SIZE_BITS     = 10;
  localparam int INDEX_BITS    = 24;
  localparam int RANK_BITS     = $clog2(MAX_RANK);
  localparam int LEN_BITS      = SIZE_BITS + 1;
  localparam int ELEM_BITS     = 64;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 11;
  localparam int ORDER_BITS    = 8;

  // register map
  localparam logic [CFG_IDX_BITS-1:0] REG_SIZE_AXIS0 = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_SIZE_AXIS3 = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_AXIS_ORDER = 3'd4;

  localparam logic [CFG_DATA_BITS-1:0] SIZE_RESET  = 11'd1;
  localparam logic [ORDER_BITS-1:0]    ORDER_RESET = 8'd228;
  localparam logic [LEN_BITS-1:0]      LEN_MAX     = LEN_BITS'(1 << SIZE_BITS);

  typedef logic [MAX_RANK-1:0][SIZE_BITS-1:0]  pos_vec_t;
  typedef logic [MAX_RANK-1:0][LEN_BITS-1:0]   len_vec_t;
  typedef logic [MAX_RANK-1:0][INDEX_BITS-1:0] idx_vec_t;

  typedef struct packed {
    logic busy;     // stride tables being rebuilt
    logic restart;  // tensor restarts: clear counters
  } seq_ctrl_t;

  typedef enum logic [2:0] {
    ST_STRIDE = 3'b001,
    ST_DELTA  = 3'b010,
    ST_RUN    = 3'b100
  } seq_state_t;

  // zero acts as 1, oversize saturates
  function automatic logic [LEN_BITS-1:0] axis_len(input logic [CFG_DATA_BITS-1:0] raw);
    logic [LEN_BITS-1:0] v;
    v = LEN_BITS'(raw);
    if (v == '0) begin
      v = LEN_BITS'(1);
    end else if (v > LEN_MAX) begin
      v = LEN_MAX;
    end
    return v;
  endfunction

endpackage

>>> hw/rtl/tap_if.sv
// Stream interfaces for source elements and addressed results.
// Depends on tap_pkg.
interface tap_in_if;
  import tap_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [ELEM_BITS-1:0] element_bits;
  modport source (output valid, output element_bits, input ready);
  modport sink   (input valid, input element_bits, output ready);
endinterface

interface tap_out_if;
  import tap_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [INDEX_BITS-1:0] dest_index;
  logic [ELEM_BITS-1:0]  element_out;
  logic                  last_element;
  modport source (output valid, output dest_index, output element_out,
                  output last_element, input ready);
  modport sink   (input valid, input dest_index, input element_out,
                  input last_element, output ready);
endinterface

>>> hw/rtl/tap_stride_seq.sv
// Config registers plus sequencer that rebuilds destination strides and
// per-axis carry deltas after reset or a size/order write. Depends on tap_pkg.
module tap_stride_seq (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [tap_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [tap_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  output tap_pkg::seq_ctrl_t                 ctrl,
  output tap_pkg::len_vec_t                  lens,
  output tap_pkg::idx_vec_t                  deltas
);
  import tap_pkg::*;

  localparam logic [RANK_BITS-1:0] STEP_TOP  = RANK_BITS'(MAX_RANK - 1);
  localparam int                   PROD_BITS = INDEX_BITS + SIZE_BITS + 1;

  logic [MAX_RANK-1:0][CFG_DATA_BITS-1:0] size_r;
  logic [ORDER_BITS-1:0]                  order_r;
  seq_state_t                             state_r;
  logic [RANK_BITS-1:0]                   step_r;
  logic [INDEX_BITS-1:0]                  acc_r;
  logic [INDEX_BITS-1:0]                  back_r;
  idx_vec_t                               stride_r;
  idx_vec_t                               delta_r;

  logic                          cfg_hit;
  logic [RANK_BITS-1:0]          sel;
  logic [PROD_BITS-1:0]          acc_prod;
  logic [PROD_BITS-1:0]          back_prod;
  logic [INDEX_BITS-1:0]         acc_nxt;
  logic [INDEX_BITS-1:0]         back_nxt;

  always_comb begin
    for (int a = 0; a < MAX_RANK; a++) begin
      lens[a] = axis_len(size_r[a]);
    end
  end

  assign cfg_hit = cfg_we && (cfg_index <= REG_AXIS_ORDER);
  // result axis i takes source axis order[2i+1:2i]
  assign sel       = order_r[{step_r, 1'b0} +: RANK_BITS];
  assign acc_prod  = PROD_BITS'(acc_r) * PROD_BITS'(lens[sel]);
  assign acc_nxt   = acc_prod[INDEX_BITS-1:0];
  assign back_prod = PROD_BITS'(lens[step_r] - LEN_BITS'(1)) * PROD_BITS'(stride_r[step_r]);
  assign back_nxt  = back_r + back_prod[INDEX_BITS-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < MAX_RANK; a++) begin
        size_r[a] <= SIZE_RESET;
      end
      order_r  <= ORDER_RESET;
      state_r  <= ST_STRIDE;
      step_r   <= STEP_TOP;
      acc_r    <= INDEX_BITS'(1);
      back_r   <= '0;
      stride_r <= '0;
    end else if (cfg_hit) begin
      if (cfg_index == REG_AXIS_ORDER) begin
        order_r <= cfg_data[ORDER_BITS-1:0];
      end else begin
        size_r[cfg_index[RANK_BITS-1:0]] <= cfg_data;
      end
      state_r  <= ST_STRIDE;
      step_r   <= STEP_TOP;
      acc_r    <= INDEX_BITS'(1);
      back_r   <= '0;
      stride_r <= '0;
    end else begin
      case (state_r)
        ST_STRIDE: begin
          // repeated axes sum their strides
          stride_r[sel] <= stride_r[sel] + acc_r;
          acc_r         <= acc_nxt;
          step_r        <= step_r - RANK_BITS'(1);
          if (step_r == '0) begin
            state_r <= ST_DELTA;
            step_r  <= STEP_TOP;
          end
        end
        ST_DELTA: begin
          // jump when this axis steps and all inner axes wrap to zero
          delta_r[step_r] <= stride_r[step_r] - back_r;
          back_r          <= back_nxt;
          step_r          <= step_r - RANK_BITS'(1);
          if (step_r == '0) begin
            state_r <= ST_RUN;
          end
        end
        ST_RUN: begin
          state_r <= ST_RUN;
        end
        default: begin
          state_r <= ST_STRIDE;
          step_r  <= STEP_TOP;
        end
      endcase
    end
  end

  assign deltas       = delta_r;
  assign ctrl.busy    = (state_r != ST_RUN);
  assign ctrl.restart = cfg_hit;

endmodule

>>> hw/rtl/tap_walk.sv
// Per-axis position counters, running destination index and a two-entry
// output buffer (result register plus skid). Depends on tap_pkg, tap_if.
module tap_walk (
  input  logic               clk,
  input  logic               rst_n,
  input  tap_pkg::seq_ctrl_t ctrl,
  input  tap_pkg::len_vec_t  lens,
  input  tap_pkg::idx_vec_t  deltas,
  tap_in_if.sink             in_ch,
  tap_out_if.source          out_ch
);
  import tap_pkg::*;

  pos_vec_t              pos_r;
  logic [INDEX_BITS-1:0] run_idx_r;
  pos_vec_t              pos_nxt;
  logic [INDEX_BITS-1:0] run_idx_nxt;
  logic [INDEX_BITS-1:0] step_delta;
  logic                  carry;
  logic                  last;
  logic                  push;
  logic                  pop;

  logic                  out_v_r;
  logic [INDEX_BITS-1:0] out_dest_r;
  logic [ELEM_BITS-1:0]  out_elem_r;
  logic                  out_last_r;
  logic                  skid_v_r;
  logic [INDEX_BITS-1:0] skid_dest_r;
  logic [ELEM_BITS-1:0]  skid_elem_r;
  logic                  skid_last_r;

  // innermost axis counts; carry ripples outward through wrapping axes
  always_comb begin
    carry      = 1'b1;
    step_delta = '0;
    for (int a = MAX_RANK - 1; a >= 0; a--) begin
      pos_nxt[a] = pos_r[a];
      if (carry) begin
        if ((LEN_BITS'(pos_r[a]) + LEN_BITS'(1)) >= lens[a]) begin
          pos_nxt[a] = '0;
        end else begin
          pos_nxt[a] = pos_r[a] + SIZE_BITS'(1);
          step_delta = deltas[a];
          carry      = 1'b0;
        end
      end
    end
    last        = carry;
    run_idx_nxt = last ? '0 : run_idx_r + step_delta;
  end

  assign in_ch.ready = !skid_v_r && !ctrl.busy;
  assign push        = in_ch.valid && in_ch.ready;
  assign pop         = out_v_r && out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.restart) begin
      pos_r     <= '0;
      run_idx_r <= '0;
    end else if (push) begin
      pos_r     <= pos_nxt;
      run_idx_r <= run_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (pop) begin
      if (skid_v_r) begin
        skid_v_r <= 1'b0;
      end else begin
        out_v_r <= push;
      end
    end else if (push) begin
      if (out_v_r) begin
        skid_v_r <= 1'b1;
      end else begin
        out_v_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && skid_v_r) begin
      out_dest_r <= skid_dest_r;
      out_elem_r <= skid_elem_r;
      out_last_r <= skid_last_r;
    end else if (push && (pop || !out_v_r)) begin
      out_dest_r <= run_idx_r;
      out_elem_r <= in_ch.element_bits;
      out_last_r <= last;
    end
    if (push && out_v_r && !pop) begin
      skid_dest_r <= run_idx_r;
      skid_elem_r <= in_ch.element_bits;
      skid_last_r <= last;
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.dest_index   = out_dest_r;
  assign out_ch.element_out  = out_elem_r;
  assign out_ch.last_element = out_last_r;

endmodule

>>> hw/rtl/tensor_axis_permute_addressing.sv
// Top level of the tensor axis permute address generator.
// Depends on tap_pkg, tap_if, tap_stride_seq and tap_walk.
//
// Usage notes:
//  - in_ch carries source elements in row-major source order (valid/ready).
//  - out_ch gives, per element, its row-major word index in the permuted
//    tensor (mod 2^24), the element bits unchanged, and a last flag on the
//    tensor's final element; counters then wrap and the next tensor starts.
//  - cfg port: cfg_we/cfg_index/cfg_data write sizes (index 0..3) and the
//    axis order (index 4). Any valid write restarts the tensor. Write only
//    while the block is idle. Indices above 4 are ignored.
//  - After reset or a config write, ready stays low while the stride
//    sequencer walks the axes: one multiply-add per cycle for strides,
//    then one per cycle for the per-axis carry deltas.
//  - Throughput: one word per cycle while out_ch takes results and the
//    sequencer is idle; each result is registered. The counter carry
//    chain plus one 24-bit add sets the per-word path.
//  - When out_ch stalls, a skid register takes one more word; ready drops
//    when both result and skid registers are full or the sequencer is busy.
module tensor_axis_permute_addressing (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [tap_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [tap_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  tap_in_if.sink                             in_ch,
  tap_out_if.source                          out_ch
);
  import tap_pkg::*;

  seq_ctrl_t ctrl;    // busy / restart from sequencer
  len_vec_t  lens;    // effective axis lengths
  idx_vec_t  deltas;  // index jump per carrying axis

  tap_stride_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ctrl      (ctrl),
    .lens      (lens),
    .deltas    (deltas)
  );

  tap_walk u_walk (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (ctrl),
    .lens   (lens),
    .deltas (deltas),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule

>>> hw/rtl/tap_checker.sv
// Port-level checks for the tensor axis permute address generator.
// Depends on tap_pkg; bound to tensor_axis_permute_addressing.
module tap_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              cfg_we,
  input logic [tap_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [tap_pkg::INDEX_BITS-1:0]    out_dest_index,
  input logic [tap_pkg::ELEM_BITS-1:0]     out_element_out,
  input logic                              out_last_element
);
  import tap_pkg::*;

  // config write forces a stride rebuild, so input must stall next cycle
  a_cfg_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_we && (cfg_index <= REG_AXIS_ORDER)) |=> !in_ready)
    else $error("input accepted right after config write");

  // first cycle out of reset is still rebuilding strides
  a_reset_stall: assert property (@(posedge clk)
    (rst_n && !$past(rst_n)) |-> !in_ready)
    else $error("input ready right after reset");

  // a result only appears after an element was taken
  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready))
    else $error("result without accepted element");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_dest_index)
      && $stable(out_element_out) && $stable(out_last_element)))
    else $error("stalled result changed");

endmodule

bind tensor_axis_permute_addressing tap_checker u_tap_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .cfg_we           (cfg_we),
  .cfg_index        (cfg_index),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_dest_index   (out_ch.dest_index),
  .out_element_out  (out_ch.element_out),
  .out_last_element (out_ch.last_element)
);

>>> tb/tb_tensor_axis_permute_addressing.sv
// Self-checking testbench for the tensor axis permute address generator:
// directed table plus randomized setting phases, checked by a local predictor.
// Depends on tap_pkg, tap_if and the tensor_axis_permute_addressing RTL.
module tb_tensor_axis_permute_addressing;
  timeunit 1ns;
  timeprecision 1ps;
  import tap_pkg::*;

  // register indexes not named in the package
  localparam logic [CFG_IDX_BITS-1:0] REG_SIZE_AXIS1  = REG_SIZE_AXIS0 + 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_SIZE_AXIS2  = REG_SIZE_AXIS0 + 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_FIRST_SPARE = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_LAST_SPARE  = 3'd7;

  // result axes 2 and 3 swapped: plain 2-D transpose of the inner axes
  localparam logic [CFG_DATA_BITS-1:0] ORDER_SWAP_INNER = 11'd180;

  localparam int N_PHASES        = 12;
  localparam int WORDS_PER_PHASE = 82;
  localparam int PRESSURE_PHASE  = 4;   // receiver holds off, sender keeps offering
  localparam int PAUSE_PHASE     = 6;   // sender waits mid-phase for a full drain
  localparam int HOLD_CYCLES     = 200;
  localparam int TAIL_CYCLES     = 8;
  localparam int RUN_LIMIT_NS    = 5_000_000;

  typedef struct {
    logic [INDEX_BITS-1:0] dest;
    logic [ELEM_BITS-1:0]  elem;
    logic                  last;
  } word_t;

  typedef enum bit {ROW_CFG, ROW_WORD} row_kind_t;

  typedef struct {
    row_kind_t              kind;
    logic [CFG_IDX_BITS-1:0]  reg_idx;
    logic [CFG_DATA_BITS-1:0] data;
    logic [ELEM_BITS-1:0]     bits;
    bit                       typed;    // expected result given in the row
    logic [INDEX_BITS-1:0]    t_dest;
    bit                       t_last;
  } row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic                     cfg_we;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;

  tap_in_if  in_bus ();
  tap_out_if out_bus ();

  tensor_axis_permute_addressing dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_bus),
    .out_ch    (out_bus)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Predictor state: own copy of the registers, counters and strides.
  // ---------------------------------------------------------------------
  logic [CFG_DATA_BITS-1:0] src_size [MAX_RANK];
  logic [ORDER_BITS-1:0]    perm_order;
  logic [SIZE_BITS-1:0]     axis_pos [MAX_RANK];
  logic [INDEX_BITS-1:0]    axis_stride [MAX_RANK];
  logic [INDEX_BITS-1:0]    running_dest;

  word_t pending_words [$];   // results still owed by the block

  int errors      = 0;
  int n_words_in  = 0;
  int n_words_out = 0;
  int n_lasts     = 0;
  int n_cfg       = 0;

  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;
  bit hold_req        = 1'b0;
  int hold_left       = 0;

  row_t directed_rows [$];

  // zero reads as length 1, anything above 2^SIZE_BITS saturates
  function automatic logic [LEN_BITS-1:0] eff_len(input int a);
    logic [LEN_BITS-1:0] v;
    v = src_size[a];
    if (v == '0) begin
      v = LEN_BITS'(1);
    end else if (v > LEN_MAX) begin
      v = LEN_MAX;
    end
    return v;
  endfunction

  // Walk result axes innermost first; the source axis each one names picks up
  // the running product as its stride. Repeated axes sum, unnamed ones stay 0.
  function automatic void rebuild_strides();
    logic [INDEX_BITS-1:0] acc;
    int s;
    acc = INDEX_BITS'(1);
    for (int i = 0; i < MAX_RANK; i++) begin
      axis_stride[i] = '0;
      axis_pos[i]    = '0;
    end
    for (int i = MAX_RANK - 1; i >= 0; i--) begin
      s = int'(perm_order[2*i +: 2]);
      axis_stride[s] = axis_stride[s] + acc;
      acc = acc * INDEX_BITS'(eff_len(s));
    end
    running_dest = '0;
  endfunction

  function automatic void apply_reg_write(input logic [CFG_IDX_BITS-1:0] idx,
                                          input logic [CFG_DATA_BITS-1:0] data);
    if (idx <= REG_SIZE_AXIS3) begin
      src_size[idx] = data;
    end else if (idx == REG_AXIS_ORDER) begin
      perm_order = data[ORDER_BITS-1:0];
    end else begin
      return;   // spare index: no effect, tensor keeps going
    end
    rebuild_strides();
  endfunction

  // One source element in: its destination index, then advance the counters.
  function automatic word_t permute_step(input logic [ELEM_BITS-1:0] bits);
    word_t w;
    logic [LEN_BITS-1:0]   nxt;
    logic [INDEX_BITS-1:0] sum;
    bit carry;
    w.dest = running_dest;
    w.elem = bits;
    w.last = 1'b1;
    for (int a = 0; a < MAX_RANK; a++) begin
      if ({1'b0, axis_pos[a]} + LEN_BITS'(1) != eff_len(a)) begin
        w.last = 1'b0;
      end
    end
    carry = 1'b1;
    for (int a = MAX_RANK - 1; a >= 0; a--) begin
      if (carry) begin
        nxt = {1'b0, axis_pos[a]} + LEN_BITS'(1);
        if (nxt >= eff_len(a)) begin
          axis_pos[a] = '0;
        end else begin
          axis_pos[a] = nxt[SIZE_BITS-1:0];
          carry = 1'b0;
        end
      end
    end
    sum = '0;
    for (int a = 0; a < MAX_RANK; a++) begin
      sum = sum + INDEX_BITS'(axis_pos[a]) * axis_stride[a];
    end
    running_dest = sum;
    return w;
  endfunction

  // ---------------------------------------------------------------------
  // Directed table builders
  // ---------------------------------------------------------------------
  function automatic void add_cfg(input logic [CFG_IDX_BITS-1:0] idx,
                                  input logic [CFG_DATA_BITS-1:0] data);
    row_t r;
    r = '{kind: ROW_CFG, reg_idx: idx, data: data, bits: '0,
          typed: 1'b0, t_dest: '0, t_last: 1'b0};
    directed_rows = {directed_rows, r};
  endfunction

  function automatic void add_word(input logic [ELEM_BITS-1:0] bits, input bit typed,
                                   input logic [INDEX_BITS-1:0] t_dest, input bit t_last);
    row_t r;
    r = '{kind: ROW_WORD, reg_idx: '0, data: '0, bits: bits,
          typed: typed, t_dest: t_dest, t_last: t_last};
    directed_rows = {directed_rows, r};
  endfunction

  // ---------------------------------------------------------------------
  // Drivers. All inputs move at the falling edge; tasks start and end there.
  // ---------------------------------------------------------------------
  // Leaves cfg_we high so back-to-back writes do not toggle it in one step;
  // the caller lowers it after the last write.
  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    apply_reg_write(idx, data);
    n_cfg++;
    @(negedge clk);
  endtask

  task automatic push_element(input logic [ELEM_BITS-1:0] bits, input bit typed,
                              input logic [INDEX_BITS-1:0] t_dest, input bit t_last);
    word_t w;
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(negedge clk);
    end
    in_bus.valid        <= 1'b1;
    in_bus.element_bits <= bits;
    do @(posedge clk); while (!in_bus.ready);
    w = permute_step(bits);
    if (typed) begin
      w.dest = t_dest;
      w.last = t_last;
    end
    pending_words = {pending_words, w};
    n_words_in++;
    @(negedge clk);
  endtask

  // Drop valid and wait until every owed word has come out (at least one step,
  // so the next raise of valid lands on a later edge).
  task automatic wait_drained();
    in_bus.valid <= 1'b0;
    do @(negedge clk); while (pending_words.size() != 0);
  endtask

  // Receiver: random stalls, or a long counted hold-off on request.
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Checker: each accepted result against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) begin : chk
      word_t exp_w;
      n_words_out++;
      if (pending_words.size() == 0) begin
        errors++;
        $display("%0t: unexpected word: dest %0h elem %0h last %0b", $time,
                 out_bus.dest_index, out_bus.element_out, out_bus.last_element);
      end else begin
        exp_w = pending_words.pop_front();
        if (out_bus.dest_index !== exp_w.dest) begin
          errors++;
          $display("%0t: dest_index expected %0h, got %0h", $time,
                   exp_w.dest, out_bus.dest_index);
        end
        if (out_bus.element_out !== exp_w.elem) begin
          errors++;
          $display("%0t: element_out expected %0h, got %0h", $time,
                   exp_w.elem, out_bus.element_out);
        end
        if (out_bus.last_element !== exp_w.last) begin
          errors++;
          $display("%0t: last_element expected %0b, got %0b", $time,
                   exp_w.last, out_bus.last_element);
        end
        if (out_bus.last_element === 1'b1) begin
          n_lasts++;
        end
      end
    end
  end

  // Hard stop far beyond the slowest legal run.
  initial begin
    #(RUN_LIMIT_NS);
    $display("Simulation FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    logic [CFG_DATA_BITS-1:0] sz;
    logic [CFG_DATA_BITS-1:0] ord;
    bit cfg_open;

    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_index           = '0;
    cfg_data            = '0;
    in_bus.valid        = 1'b0;
    in_bus.element_bits = '0;
    out_bus.ready       = 1'b0;

    // predictor reset: unit sizes, identity order
    for (int a = 0; a < MAX_RANK; a++) begin
      src_size[a] = SIZE_RESET;
    end
    perm_order = ORDER_RESET;
    rebuild_strides();

    // Directed table.
    // After reset every axis is 1 long: each word is index 0 and last.
    add_word(64'h0, 1'b1, 24'd0, 1'b1);
    add_word('1, 1'b1, 24'd0, 1'b1);
    // 2x3 inner matrix, axes 2/3 swapped: (r,c) lands at c*2 + r
    add_cfg(REG_SIZE_AXIS2, 11'd2);
    add_cfg(REG_SIZE_AXIS3, 11'd3);
    add_cfg(REG_AXIS_ORDER, ORDER_SWAP_INNER);
    add_word(64'hAAAA_AAAA_AAAA_AAAA, 1'b1, 24'd0, 1'b0);
    add_word(64'h5555_5555_5555_5555, 1'b1, 24'd2, 1'b0);
    add_word(64'h8000_0000_0000_0001, 1'b1, 24'd4, 1'b0);
    add_word(64'h0123_4567_89AB_CDEF, 1'b1, 24'd1, 1'b0);
    add_word(64'hFEDC_BA98_7654_3210, 1'b1, 24'd3, 1'b0);
    add_word(64'h7FFF_FFFF_FFFF_FFFE, 1'b1, 24'd5, 1'b1);
    // counters wrapped: next tensor starts at 0
    add_word(64'h0000_0000_FFFF_FFFF, 1'b1, 24'd0, 1'b0);
    // spare register indexes must leave the walk where it was
    add_cfg(REG_FIRST_SPARE, 11'h7FF);
    add_word(64'hFFFF_FFFF_0000_0000, 1'b0, '0, 1'b0);
    add_cfg(REG_LAST_SPARE, 11'h000);
    add_word(64'h1, 1'b0, '0, 1'b0);
    // oversize saturates, zero acts as 1, every result axis on source axis 0
    add_cfg(REG_SIZE_AXIS0, 11'h7FF);
    add_cfg(REG_SIZE_AXIS1, 11'd0);
    add_cfg(REG_SIZE_AXIS2, 11'd0);
    add_cfg(REG_SIZE_AXIS3, 11'd0);
    add_cfg(REG_AXIS_ORDER, 11'd0);
    for (int k = 0; k < 5; k++) begin
      add_word({$urandom, $urandom}, 1'b0, '0, 1'b0);
    end
    // all result axes on source axis 3, innermost at the maximum length
    add_cfg(REG_SIZE_AXIS3, 11'd1024);
    add_cfg(REG_AXIS_ORDER, 11'hFF);
    for (int k = 0; k < 3; k++) begin
      add_word({$urandom, $urandom}, 1'b0, '0, 1'b0);
    end

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    cfg_open = 1'b0;
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        // consecutive writes go back to back, so none is repeated
        if (!cfg_open) begin
          wait_drained();
        end
        write_reg(directed_rows[i].reg_idx, directed_rows[i].data);
        cfg_open = 1'b1;
      end else begin
        if (cfg_open) begin
          cfg_we   <= 1'b0;
          cfg_open = 1'b0;
        end
        push_element(directed_rows[i].bits, directed_rows[i].typed,
                     directed_rows[i].t_dest, directed_rows[i].t_last);
      end
    end

    // Random phases: new setting each phase (or only a spare-index write,
    // so the tensor runs on across the phase), then a stream of words.
    for (int ph = 0; ph < N_PHASES; ph++) begin
      wait_drained();
      if (ph % 5 == 3) begin
        write_reg(CFG_IDX_BITS'($urandom_range(REG_FIRST_SPARE, REG_LAST_SPARE)),
                  CFG_DATA_BITS'($urandom_range(0, 2047)));
      end else begin
        for (int r = 0; r < MAX_RANK; r++) begin
          case ($urandom_range(0, 9))
            0: sz = '0;
            8: sz = CFG_DATA_BITS'($urandom_range(0, 2047));
            9: begin
              case ($urandom_range(0, 2))
                0: sz = 11'd1023;
                1: sz = 11'd1024;
                default: sz = 11'h7FF;
              endcase
            end
            default: sz = CFG_DATA_BITS'($urandom_range(1, 5));
          endcase
          if (ph == 1) begin
            sz = 11'h7FF;   // every axis saturated: destination wraps fast
          end else if (ph == 2) begin
            sz = '0;        // single-element tensor: every word is last
          end
          write_reg(REG_SIZE_AXIS0 + CFG_IDX_BITS'(r), sz);
        end
        case ($urandom_range(0, 5))
          0: ord = CFG_DATA_BITS'(ORDER_RESET);
          1: ord = '0;
          2: ord = 11'hFF;
          default: ord = CFG_DATA_BITS'($urandom_range(0, 2047));
        endcase
        if (ph == 1) begin
          ord = 11'hFF;
        end else if (ph == 2) begin
          ord = '0;
        end
        write_reg(REG_AXIS_ORDER, ord);
      end
      cfg_we <= 1'b0;

      // idle mix cycles: none, sender idle, receiver stalls, both
      case (ph % 4)
        0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin sender_idle_pct = 79; recv_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  recv_stall_pct = 79; end
        default: begin sender_idle_pct = 32; recv_stall_pct = 32; end
      endcase
      if (ph == PRESSURE_PHASE) begin
        hold_req = 1'b1;   // block fills its two slots, then ready drops
      end

      for (int k = 0; k < WORDS_PER_PHASE; k++) begin
        if (ph == PAUSE_PHASE && k == WORDS_PER_PHASE / 2) begin
          wait_drained();
        end
        push_element({$urandom, $urandom}, 1'b0, '0, 1'b0);
      end
    end

    // drain, then give the block a few more cycles to show any stray word
    wait_drained();
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    repeat (TAIL_CYCLES) @(negedge clk);
    if (pending_words.size() != 0) begin
      errors++;
      $display("%0t: %0d expected words never arrived", $time, pending_words.size());
    end

    $display("Covered %0d source words, %0d results (%0d tensor ends), %0d register writes,",
             n_words_in, n_words_out, n_lasts, n_cfg);
    $display("over %0d setting phases with mixed stalls, one long hold-off and a drain pause.",
             N_PHASES);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
